>>> hdl/rle_text_encoder_core_macros.svh
// Assertion macros shared by the checker of the run-length text encoder.
// Depends on nothing; the including scope must provide clk_i and rst_ni.
`ifndef RLE_TEXT_ENCODER_CORE_MACROS_SVH
`define RLE_TEXT_ENCODER_CORE_MACROS_SVH

// Concurrent assertion on the rising clock, disabled while reset is asserted.
`define RLE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Next-cycle rule: the consequent holds in the cycle after the antecedent holds.
`define RLE_ASSERT_NEXT(name, ante, cons, msg) \
  `RLE_ASSERT(name, (ante) |=> (cons), msg)

`endif

>>> hdl/rle_pkg.sv
// Shared types, constants and helper functions of the run-length text encoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package rle_pkg;

  // Sizes of the data path.
  localparam int unsigned ByteW     = 8;
  localparam int unsigned RunLenW   = 16;
  localparam int unsigned PosW      = 3;
  localparam int unsigned ThrW      = 17;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  // Longest run before it is closed and emitted.
  localparam int unsigned MaxRun = 65535;
  localparam logic [RunLenW-1:0] MaxRunLen = RunLenW'(MaxRun);

  // Character constants.
  localparam logic [ByteW-1:0] AsciiZero = 8'h30;
  localparam logic [ByteW-1:0] AsciiNine = 8'h39;
  localparam logic [ByteW-1:0] SepReset  = 8'h2E;

  // Configuration port geometry and register indexes.
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = CfgAddrW - 2;
  localparam logic [CfgIdxW-1:0] RegSeparator = 1'b0;

  // Input word.
  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             in_final;
  } in_item_t;

  // Output word.
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             out_last;
    logic             out_stream_end;
  } out_item_t;

  // One closed run: its byte and its length.
  typedef struct packed {
    logic [ByteW-1:0]   value;
    logic [RunLenW-1:0] length;
  } run_t;

  // Work handed from the front to the back for one input word.
  typedef struct packed {
    logic has_old;
    run_t old_run;
    logic has_cur;
    run_t cur_run;
    logic fin;
  } rec_t;

  // Position of the most significant decimal digit of a run length.
  function automatic logic [PosW-1:0] top_digit_pos(logic [RunLenW-1:0] len);
    logic [PosW-1:0] pos;
    pos = 3'd0;
    if (len >= 16'd10000) begin
      pos = 3'd4;
    end else if (len >= 16'd1000) begin
      pos = 3'd3;
    end else if (len >= 16'd100) begin
      pos = 3'd2;
    end else if (len >= 16'd10) begin
      pos = 3'd1;
    end
    return pos;
  endfunction

  // k times the decimal weight of digit position pos.
  function automatic logic [ThrW-1:0] digit_threshold(logic [PosW-1:0] pos, int unsigned k);
    logic [ThrW-1:0] thr;
    case (pos)
      3'd0:    thr = ThrW'(k);
      3'd1:    thr = ThrW'(k * 10);
      3'd2:    thr = ThrW'(k * 100);
      3'd3:    thr = ThrW'(k * 1000);
      3'd4:    thr = ThrW'(k * 10000);
      default: thr = ThrW'(k);
    endcase
    return thr;
  endfunction

  // True for the ASCII characters '0' to '9'.
  function automatic logic is_digit(logic [ByteW-1:0] b);
    return (b >= AsciiZero) && (b <= AsciiNine);
  endfunction

endpackage

>>> hdl/rle_front.sv
// Front of the run-length text encoder: tracks the open run and classifies
// each accepted byte into the runs it closes. Depends on rle_pkg.
module rle_front
  import rle_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  output logic     in_stall_o,
  input  logic     full_i,
  output logic     push_o,
  output rec_t     push_rec_o
);

  logic               run_open_q, run_open_d;
  logic [ByteW-1:0]   run_value_q, run_value_d;
  logic [RunLenW-1:0] run_length_q, run_length_d;

  logic               accept;
  logic               same;
  logic               close_cur;
  logic [RunLenW-1:0] cur_len;
  rec_t               rec;

  // The queue decides whether a new word can be taken.
  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // Classify the word against the open run.
  always_comb begin
    same         = run_open_q && (run_value_q == in_item_i.in_byte);
    cur_len      = same ? (run_length_q + 16'd1) : 16'd1;
    close_cur    = (cur_len >= MaxRunLen) || in_item_i.in_final;

    rec.has_old        = run_open_q && !same;
    rec.old_run.value  = run_value_q;
    rec.old_run.length = run_length_q;
    rec.has_cur        = close_cur;
    rec.cur_run.value  = in_item_i.in_byte;
    rec.cur_run.length = cur_len;
    rec.fin            = in_item_i.in_final;

    run_open_d   = run_open_q;
    run_value_d  = run_value_q;
    run_length_d = run_length_q;
    if (accept) begin
      run_open_d   = !close_cur;
      run_value_d  = in_item_i.in_byte;
      run_length_d = close_cur ? '0 : cur_len;
    end
  end

  // Only words that close at least one run produce work for the back.
  assign push_o     = accept && (rec.has_old || rec.has_cur);
  assign push_rec_o = rec;

  // Open-run state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q   <= 1'b0;
      run_value_q  <= '0;
      run_length_q <= '0;
    end else begin
      run_open_q   <= run_open_d;
      run_value_q  <= run_value_d;
      run_length_q <= run_length_d;
    end
  end

endmodule

>>> hdl/rle_fifo.sv
// Short queue of run records between the front and the back of the encoder.
// Depends on rle_pkg.
module rle_fifo
  import rle_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t push_rec_i,
  input  logic pop_i,
  output rec_t head_o,
  output logic empty_o,
  output logic full_o
);

  rec_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == FifoCntW'(FifoDepth));
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Record storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule

>>> hdl/rle_back.sv
// Back of the run-length text encoder: expands queued run records into encoded
// bytes, one per cycle unless stalled, behind an output register. Needs rle_pkg.
module rle_back
  import rle_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ByteW-1:0] separator_i,
  input  rec_t             head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  output out_item_t        out_item_o,
  input  logic             out_stall_i
);

  // Sequencer steps within one run.
  localparam logic [1:0] StepDigit = 2'd0;
  localparam logic [1:0] StepSep   = 2'd1;
  localparam logic [1:0] StepByte  = 2'd2;

  logic               busy_q, busy_d;
  rec_t               rec_q, rec_d;
  logic               phase_q, phase_d;
  logic [1:0]         step_q, step_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [RunLenW-1:0] rem_q, rem_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_item_q, out_item_d;

  logic               out_ready;
  logic               advance;
  logic               emit;
  out_item_t          emit_item;
  logic               load_rec;
  logic               start_run;
  run_t               start_sel;
  run_t               run;
  logic [3:0]         digit;
  logic [ThrW-1:0]    digit_sub;
  logic [ThrW-1:0]    rem_ext;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign advance   = busy_q && out_ready;
  assign run       = phase_q ? rec_q.cur_run : rec_q.old_run;
  assign rem_ext   = {1'b0, rem_q};

  // Current decimal digit: the largest multiple of the position weight that fits.
  always_comb begin
    digit     = 4'd0;
    digit_sub = '0;
    for (int unsigned k = 1; k < 10; k++) begin
      if (rem_ext >= digit_threshold(pos_q, k)) begin
        digit     = 4'(k);
        digit_sub = digit_threshold(pos_q, k);
      end
    end
  end

  // Sequencer: digits, optional separator, run byte; then the next run.
  always_comb begin
    busy_d    = busy_q;
    rec_d     = rec_q;
    phase_d   = phase_q;
    step_d    = step_q;
    pos_d     = pos_q;
    rem_d     = rem_q;
    emit      = 1'b0;
    emit_item = '0;
    load_rec  = 1'b0;
    start_run = 1'b0;
    start_sel = rec_q.cur_run;

    if (advance) begin
      emit = 1'b1;
      case (step_q)
        StepDigit: begin
          emit_item.out_byte = AsciiZero + {4'b0, digit};
          rem_d = RunLenW'(rem_ext - digit_sub);
          if (pos_q == '0) begin
            step_d = is_digit(run.value) ? StepSep : StepByte;
          end else begin
            pos_d = pos_q - 1'b1;
          end
        end
        StepSep: begin
          emit_item.out_byte = separator_i;
          step_d = StepByte;
        end
        StepByte: begin
          emit_item.out_byte = run.value;
          if (!phase_q && rec_q.has_cur) begin
            phase_d   = 1'b1;
            start_run = 1'b1;
            start_sel = rec_q.cur_run;
          end else begin
            emit_item.out_last       = 1'b1;
            emit_item.out_stream_end = rec_q.fin;
            if (!empty_i) begin
              load_rec = 1'b1;
            end else begin
              busy_d = 1'b0;
            end
          end
        end
        default: begin
          step_d = StepByte;
        end
      endcase
    end else if (!busy_q && !empty_i) begin
      load_rec = 1'b1;
    end

    // Take the next record from the queue.
    if (load_rec) begin
      busy_d    = 1'b1;
      rec_d     = head_i;
      phase_d   = !head_i.has_old;
      start_run = 1'b1;
      start_sel = head_i.has_old ? head_i.old_run : head_i.cur_run;
    end

    // A run of one is the bare byte; a longer run starts with its top digit.
    if (start_run) begin
      rem_d  = start_sel.length;
      pos_d  = top_digit_pos(start_sel.length);
      step_d = (start_sel.length > 16'd1) ? StepDigit : StepByte;
    end
  end

  assign pop_o = load_rec;

  // Output register parts the sequencer from the consumer.
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_ready) begin
      out_valid_d = emit;
      out_item_d  = emit_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= 1'b0;
      step_q      <= StepByte;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    rec_q      <= rec_d;
    pos_q      <= pos_d;
    rem_q      <= rem_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> hdl/rle_text_encoder_core.sv
// Top level of the run-length text encoder: configuration port and the
// front, queue and back. Depends on rle_pkg, rle_front, rle_fifo and rle_back.
//
// The encoder takes one text byte per cycle unless the input stalls. The front
// updates the open run in the cycle a word is accepted and hands every closed
// run to a four-entry queue; the back expands each closed run into bytes, one
// byte per cycle unless the output stalls: a run of one becomes the bare byte,
// a longer run its decimal digits, then the separator when the repeated byte
// is a decimal digit, then the byte. A word that closes no run produces no
// output. The input stalls only while the queue is full, i.e. while the back
// sequencer's output is behind. An accepted word passes through the queue,
// the back's record register and the output register.
module rle_text_encoder_core
  import rle_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Text input.
  input  logic                in_valid_i,
  input  in_item_t            in_item_i,
  output logic                in_stall_o,
  // Encoded output.
  output logic                out_valid_o,
  output out_item_t           out_item_o,
  input  logic                out_stall_i,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  logic [ByteW-1:0]   sep_q, sep_d;
  logic [CfgIdxW-1:0] reg_idx;
  logic               push;
  rec_t               push_rec;
  logic               pop;
  rec_t               head;
  logic               empty;
  logic               full;

  // Separator register at register index zero; other addresses are ignored.
  assign reg_idx = paddr[CfgAddrW-1:2];
  assign pready  = 1'b1;

  always_comb begin
    sep_d = sep_q;
    if (psel && penable && pwrite && (reg_idx == RegSeparator)) begin
      sep_d = pwdata[ByteW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == RegSeparator) begin
      prdata = {{(CfgDataW - ByteW){1'b0}}, sep_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SepReset;
    end else begin
      sep_q <= sep_d;
    end
  end

  rle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .full_i     (full),
    .push_o     (push),
    .push_rec_o (push_rec)
  );

  rle_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty),
    .full_o     (full)
  );

  rle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .separator_i (sep_q),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

>>> hdl/rle_checker.sv
// Port-level checker of the run-length text encoder and its bind to the top.
// Depends on rle_pkg and rle_text_encoder_core_macros.svh.
`include "rle_text_encoder_core_macros.svh"

module rle_checker
  import rle_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input in_item_t            in_item_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input out_item_t           out_item_o,
  input logic                out_stall_i,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [CfgAddrW-1:0] paddr,
  input logic [CfgDataW-1:0] pwdata,
  input logic [CfgDataW-1:0] prdata,
  input logic                pready
);

  // A stalled input word stays offered with the same contents.
  `RLE_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o,
                   in_valid_i && $stable(in_item_i), "stalled input word changed")

  // A stalled output word stays offered.
  `RLE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o,
                   "output word dropped under stall")

  // A stalled output word keeps its contents.
  `RLE_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_item_o),
                   "stalled output word changed")

  // The end of the text is always the last byte of its input word.
  `RLE_ASSERT(a_end_is_last,
              out_valid_o && out_item_o.out_stream_end |-> out_item_o.out_last,
              "stream end without last flag")

  // A separator write reads back on the following cycle.
  `RLE_ASSERT_NEXT(a_sep_readback,
                   psel && penable && pwrite && pready && (paddr[2] == 1'b0),
                   (paddr[2] != 1'b0) || (prdata == {24'b0, $past(pwdata[7:0])}),
                   "separator readback mismatch")

endmodule

bind rle_text_encoder_core rle_checker u_checker (.*);
